[hdl/mdvt_pkg.sv]
// Shared constants for the max-degree vertex tracker: field widths,
// item kind codes and the configuration register map. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mdvt_pkg;

    // Width of a node number and of the reported degree on the ports.
    localparam int NODE_W    = 21;
    localparam int OUT_DEG_W = 21;

    // Packed widths of the stream payloads, rounded up to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Item kinds carried in s_tuser.
    typedef enum logic {
        OP_EDGE  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // Configuration register map.
    localparam int                CFG_ADDR_W      = 2;
    localparam logic [CFG_ADDR_W-1:0] ADDR_NODE_COUNT = 2'd0;

    localparam logic [NODE_W-1:0]    NODE_COUNT_RESET = 21'h100000;
    localparam logic [NODE_W-1:0]    NODE_MAX         = 21'h1FFFFF;
    localparam logic [OUT_DEG_W-1:0] OUT_DEG_MAX      = 21'h1FFFFF;

endpackage : mdvt_pkg

`default_nettype wire

[hdl/max_degree_vertex_tracker_core.sv]
// A query's result is registered on m_tdata in the cycle after the query item is taken.
// An edge with two distinct ends makes two read-modify-writes on the degree memory;
// a self-loop makes one, and a rejected edge or a query makes none.
// Reset: aresetn (synchronous, active low) starts a clearing pass that zeroes the
// degree memory one entry per cycle; no item is taken until it ends.
// Top level of the max-degree vertex tracker; depends on mdvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module max_degree_vertex_tracker_core
    import mdvt_pkg::*;
#(
    parameter int NODES       = 1048576,
    parameter int DEGREE_BITS = 21
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Input item channel.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata: end_a [20:0], end_b [41:21], zero [47:42]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: op [0] (0 = add edge, 1 = query)
    input  wire logic                  s_tuser,

    // Result item channel.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata: best_node [20:0], best_degree [41:21], bad_edge_seen [42], zero [47:43]
    output logic [M_TDATA_W-1:0]       m_tdata,

    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // ------------------------------------------------------------------
    // Derived sizes. The memory index is the node number minus one, so it
    // needs only enough bits for NODES entries.
    // ------------------------------------------------------------------
    localparam int IDX_W  = $clog2(NODES);
    localparam int WIDE_W = (IDX_W > NODE_W) ? IDX_W : NODE_W;
    localparam int OW     = (DEGREE_BITS > OUT_DEG_W) ? DEGREE_BITS : OUT_DEG_W;

    localparam logic [DEGREE_BITS-1:0] DEG_MAX = {DEGREE_BITS{1'b1}};
    localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(NODES - 1);

    // Highest node number that can ever be valid, limited by the 21-bit field.
    localparam logic [NODE_W-1:0] NODE_CAP =
        (NODES > 2097151) ? NODE_MAX : NODE_W'(NODES);
    // Effective count right after reset; it is also the initial best node.
    localparam logic [NODE_W-1:0] RESET_BEST =
        (NODE_COUNT_RESET > NODE_CAP) ? NODE_CAP : NODE_COUNT_RESET;

    function automatic logic [IDX_W-1:0] node_index(input logic [NODE_W-1:0] n);
        logic [WIDE_W-1:0] w;
        begin
            w = WIDE_W'(n) - WIDE_W'(1);
            return w[IDX_W-1:0];
        end
    endfunction

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUMP_A,
        ST_BUMP_B
    } state_t;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        clr_idx_reg, clr_idx_next;
    logic [NODE_W-1:0]       count_reg, count_next;
    logic [NODE_W-1:0]       best_node_reg, best_node_next;
    logic [DEGREE_BITS-1:0]  best_deg_reg, best_deg_next;
    logic                    bad_reg, bad_next;
    logic [NODE_W-1:0]       end_a_reg, end_a_next;
    logic [NODE_W-1:0]       end_b_reg, end_b_next;
    logic                    self_reg, self_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    // Degree memory: one write port and one read port with registered data.
    logic [DEGREE_BITS-1:0]  deg_mem [NODES];
    logic [DEGREE_BITS-1:0]  rd_data_reg;
    logic                    fwd_hit_reg;
    logic [DEGREE_BITS-1:0]  fwd_data_reg;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [DEGREE_BITS-1:0]  wr_data;

    // ------------------------------------------------------------------
    // Input decode and range check against the effective node count.
    // ------------------------------------------------------------------
    logic [NODE_W-1:0] in_a;
    logic [NODE_W-1:0] in_b;
    logic [NODE_W-1:0] eff_count;
    logic              in_bad;
    logic              s_accept;
    logic              cfg_write;

    assign in_a = s_tdata[NODE_W-1:0];
    assign in_b = s_tdata[2*NODE_W-1:NODE_W];

    // A count of zero acts as one node; a count above the memory acts as its size.
    assign eff_count = (count_reg == '0) ? NODE_W'(1) :
                       ((count_reg > NODE_CAP) ? NODE_CAP : count_reg);

    assign in_bad = (in_a == '0) || (in_b == '0) || (in_a > eff_count) || (in_b > eff_count);

    // A new item may enter when the core is idle or the current one is on its last memory write,
    // as long as the output register is free or being emptied this cycle.
    assign s_tready = ((state_reg == ST_IDLE) ||
                       (state_reg == ST_BUMP_A && self_reg) ||
                       (state_reg == ST_BUMP_B)) &&
                      (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr == ADDR_NODE_COUNT) ? {{(32 - NODE_W){1'b0}}, count_reg} : '0;

    // ------------------------------------------------------------------
    // Shared bump unit. It adds one (or two for a self-loop) to the degree
    // just read, saturates, and compares against the running best.
    // ------------------------------------------------------------------
    logic [NODE_W-1:0]      bump_node;
    logic [DEGREE_BITS-1:0] cur_deg;
    logic [DEGREE_BITS:0]   sum_deg;
    logic [DEGREE_BITS-1:0] new_deg;
    logic                   bump_en;
    logic                   takes_best;

    assign bump_en   = (state_reg == ST_BUMP_A) || (state_reg == ST_BUMP_B);
    assign bump_node = (state_reg == ST_BUMP_B) ? end_b_reg : end_a_reg;
    // A read that hit the entry written in the same cycle takes the written value.
    assign cur_deg   = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign sum_deg   = {1'b0, cur_deg} +
                       (((state_reg == ST_BUMP_A) && self_reg) ? (DEGREE_BITS + 1)'(2)
                                                               : (DEGREE_BITS + 1)'(1));
    assign new_deg   = sum_deg[DEGREE_BITS] ? DEG_MAX : sum_deg[DEGREE_BITS-1:0];
    assign takes_best = (new_deg > best_deg_reg) ||
                        ((new_deg == best_deg_reg) && (bump_node > best_node_reg));

    // ------------------------------------------------------------------
    // Memory port control.
    // ------------------------------------------------------------------
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = node_index(in_a);
        wr_en   = 1'b0;
        wr_addr = node_index(bump_node);
        wr_data = new_deg;
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '0;
        end else begin
            wr_en = bump_en;
            if (s_accept) begin
                rd_en   = 1'b1;
                rd_addr = node_index(in_a);
            end else if (state_reg == ST_BUMP_A && !self_reg) begin
                rd_en   = 1'b1;
                rd_addr = node_index(end_b_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            deg_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= deg_mem[rd_addr];
        end
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (rd_addr == wr_addr);
        end
    end

    // ------------------------------------------------------------------
    // Next-state logic for the sequencer, the best tracker and the output.
    // ------------------------------------------------------------------
    logic [OW-1:0]        deg_wide;
    logic [OUT_DEG_W-1:0] out_deg;

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        count_next     = count_reg;
        best_node_next = best_node_reg;
        best_deg_next  = best_deg_reg;
        bad_next       = bad_reg;
        end_a_next     = end_a_reg;
        end_b_next     = end_b_reg;
        self_next      = self_reg;
        m_tvalid_next  = m_tvalid_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                state_next = ST_IDLE;
            end
            ST_BUMP_A: begin
                state_next = self_reg ? ST_IDLE : ST_BUMP_B;
            end
            ST_BUMP_B: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (bump_en && takes_best) begin
            best_node_next = bump_node;
            best_deg_next  = new_deg;
        end

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (s_accept) begin
            end_a_next = in_a;
            end_b_next = in_b;
            self_next  = (in_a == in_b);
            if (op_t'(s_tuser) == OP_QUERY) begin
                m_tvalid_next = 1'b1;
                state_next    = ST_IDLE;
            end else if (in_bad) begin
                bad_next   = 1'b1;
                state_next = ST_IDLE;
            end else begin
                state_next = ST_BUMP_A;
            end
        end

        // A new count reloads the best only while no edge has been counted.
        if (cfg_write && paddr == ADDR_NODE_COUNT) begin
            count_next = pwdata[NODE_W-1:0];
            if (best_deg_next == '0) begin
                best_node_next = (pwdata[NODE_W-1:0] == '0) ? NODE_W'(1) :
                                 ((pwdata[NODE_W-1:0] > NODE_CAP) ? NODE_CAP
                                                                  : pwdata[NODE_W-1:0]);
            end
        end
    end

    // The reported degree saturates at the port width when the store is wider.
    assign deg_wide = OW'(best_deg_next);
    assign out_deg  = (deg_wide > OW'(OUT_DEG_MAX)) ? OUT_DEG_MAX : deg_wide[OUT_DEG_W-1:0];

    always_comb begin
        m_tdata_next = m_tdata_reg;
        if (s_accept && op_t'(s_tuser) == OP_QUERY) begin
            m_tdata_next = {{(M_TDATA_W - 2*NODE_W - 1){1'b0}}, bad_next, out_deg,
                            best_node_next};
        end
    end

    // ------------------------------------------------------------------
    // State and registered outputs.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            count_reg     <= NODE_COUNT_RESET;
            best_node_reg <= RESET_BEST;
            best_deg_reg  <= '0;
            bad_reg       <= 1'b0;
            self_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            count_reg     <= count_next;
            best_node_reg <= best_node_next;
            best_deg_reg  <= best_deg_next;
            bad_reg       <= bad_next;
            self_reg      <= self_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        end_a_reg   <= end_a_next;
        end_b_reg   <= end_b_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule : max_degree_vertex_tracker_core

`default_nettype wire
